// ===== sv/bsp_pkg.sv =====
`timescale 1ns / 1ps
// Shared widths, defaults and the command/status bundles of the sweep point generator.
// Used by bsp_interp, bsp_ctrl, bsp_dpath and boustrophedon_sweep_points.
package bsp_pkg;

    localparam int COORD_W       = 32;
    localparam int SPACING_W     = 31;
    localparam int MAX_LINES_DEF = 32;
    localparam int MAG_W         = COORD_W + 1;
    localparam int HALF_W        = COORD_W / 2;
    localparam int PROD_W        = COORD_W + MAG_W;
    localparam int QUO_W         = COORD_W + 1;
    localparam int DIV_CNT_W     = $clog2(QUO_W);

    localparam logic [SPACING_W-1:0] SPACING_RESET = SPACING_W'(65536);

    typedef struct packed {
        logic load;
        logic init;
        logic start;
        logic emit;
        logic advance;
    } t_cmd;

    typedef struct packed {
        logic bad;
        logic done;
        logic out_free;
        logic last_pt;
    } t_sts;

endpackage

// ===== sv/bsp_interp.sv =====
`timescale 1ns / 1ps
// Iterative interpolator: a + round((b - a) * dx / w) with a split multiply and a
// restoring divider that retires one quotient bit per cycle. Depends on bsp_pkg.
module bsp_interp
    import bsp_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic signed [COORD_W-1:0] i_a,
    input  logic signed [COORD_W-1:0] i_b,
    input  logic        [COORD_W-1:0] i_dx,
    input  logic        [COORD_W-1:0] i_w,
    output logic                      o_done,
    output logic        [COORD_W-1:0] o_y
);

    typedef enum logic [2:0] {
        P_IDLE,
        P_MLO,
        P_MHI,
        P_SUM,
        P_DIV,
        P_RND
    } t_phase;

    t_phase                r_phase;
    logic                  r_done;
    logic [DIV_CNT_W-1:0]  r_cnt;

    logic                  r_neg;
    logic [COORD_W-1:0]    r_a;
    logic [MAG_W-1:0]      r_m;
    logic [COORD_W-1:0]    r_dx;
    logic [COORD_W-1:0]    r_w;
    logic [MAG_W+HALF_W-1:0] r_plo;
    logic [MAG_W+HALF_W-1:0] r_phi;
    logic [COORD_W-1:0]    r_rem;
    logic [QUO_W-1:0]      r_dvd;
    logic [QUO_W-1:0]      r_quo;
    logic [COORD_W-1:0]    r_y;

    logic [MAG_W-1:0]      s_diff;
    logic [PROD_W-1:0]     s_prod;
    logic [COORD_W:0]      s_trial;
    logic                  s_ge;
    logic                  s_round;
    logic [COORD_W+1:0]    s_mag;
    logic [COORD_W+1:0]    s_ext_a;
    logic [COORD_W+1:0]    s_y;

    always_comb begin
        s_diff  = {i_b[COORD_W-1], i_b} - {i_a[COORD_W-1], i_a};
        s_prod  = {{HALF_W{1'b0}}, r_plo} + {r_phi, {HALF_W{1'b0}}};
        s_trial = {r_rem, r_dvd[QUO_W-1]};
        s_ge    = s_trial >= {1'b0, r_w};
        s_round = {r_rem, 1'b0} >= {1'b0, r_w};
        s_mag   = {1'b0, r_quo} + (COORD_W+2)'(s_round);
        s_ext_a = {{2{r_a[COORD_W-1]}}, r_a};
        s_y     = r_neg ? s_ext_a - s_mag : s_ext_a + s_mag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= P_IDLE;
            r_done  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_done <= 1'b0;
            case (r_phase)
                P_IDLE: begin
                    if (i_start) begin
                        r_phase <= P_MLO;
                    end
                end
                P_MLO: r_phase <= P_MHI;
                P_MHI: r_phase <= P_SUM;
                P_SUM: begin
                    r_cnt   <= '0;
                    r_phase <= P_DIV;
                end
                P_DIV: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == DIV_CNT_W'(QUO_W - 1)) begin
                        r_phase <= P_RND;
                    end
                end
                P_RND: begin
                    r_done  <= 1'b1;
                    r_phase <= P_IDLE;
                end
                default: r_phase <= P_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_phase)
            P_IDLE: begin
                if (i_start) begin
                    r_neg <= s_diff[MAG_W-1];
                    r_m   <= s_diff[MAG_W-1] ? (MAG_W)'(-s_diff) : s_diff;
                    r_a   <= i_a;
                    r_dx  <= i_dx;
                    r_w   <= i_w;
                end
            end
            P_MLO: r_plo <= r_m * r_dx[HALF_W-1:0];
            P_MHI: r_phi <= r_m * r_dx[COORD_W-1:HALF_W];
            P_SUM: begin
                r_rem <= s_prod[PROD_W-1:QUO_W];
                r_dvd <= s_prod[QUO_W-1:0];
            end
            P_DIV: begin
                r_rem <= s_ge ? COORD_W'(s_trial - {1'b0, r_w}) : s_trial[COORD_W-1:0];
                r_quo <= {r_quo[QUO_W-2:0], s_ge};
                r_dvd <= {r_dvd[QUO_W-2:0], 1'b0};
            end
            P_RND: r_y <= s_y[COORD_W-1:0];
            default: ;
        endcase
    end

    assign o_done = r_done;
    assign o_y    = r_y;

endmodule

// ===== sv/bsp_dpath.sv =====
`timescale 1ns / 1ps
// Datapath: spacing register, cell registers, line and point counters, operand
// selection for the interpolator and the output register. Depends on bsp_pkg, bsp_interp.
module bsp_dpath
    import bsp_pkg::*;
#(
    parameter int MAX_LINES = MAX_LINES_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [SPACING_W-1:0]      i_cfg_wdata,
    input  logic [6*COORD_W-1:0]      i_cell,
    input  t_cmd                      i_cmd,
    output t_sts                      o_sts,
    input  logic                      i_out_ready,
    output logic                      o_out_valid,
    output logic [2*COORD_W-1:0]      o_out_data,
    output logic                      o_out_last,
    output logic [1:0]                o_out_user
);

    localparam int LineW = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
    localparam int ClipW = SPACING_W + $clog2(MAX_LINES + 1);

    logic [SPACING_W-1:0] r_spacing;
    logic [COORD_W-1:0]   r_clx;
    logic [COORD_W-1:0]   r_cly;
    logic [COORD_W-1:0]   r_cry;
    logic [COORD_W-1:0]   r_fly;
    logic [COORD_W-1:0]   r_fry;
    logic [COORD_W:0]     r_w;
    logic [COORD_W-1:0]   r_dx;
    logic [LineW-1:0]     r_line;
    logic                 r_pt;
    logic                 r_bad;
    logic                 r_clip;

    logic                 r_out_valid;
    logic [COORD_W-1:0]   r_out_x;
    logic [COORD_W-1:0]   r_out_y;
    logic                 r_out_last;
    logic                 r_out_bad;
    logic                 r_out_clip;

    logic                 s_bad;
    logic                 s_clip;
    logic [ClipW-1:0]     s_span;
    logic [COORD_W:0]     s_next_dx;
    logic                 s_final;
    logic                 s_last_pt;
    logic                 s_sel_ceil;
    logic [COORD_W-1:0]   s_a;
    logic [COORD_W-1:0]   s_b;
    logic                 s_done;
    logic [COORD_W-1:0]   s_y;

    always_comb begin
        s_bad      = r_w[COORD_W] || (r_w == '0) || (r_spacing == '0);
        s_span     = ClipW'(r_spacing) * ClipW'(MAX_LINES);
        s_clip     = s_span <= ClipW'(r_w[COORD_W-1:0]);
        s_next_dx  = {1'b0, r_dx} + (COORD_W+1)'(r_spacing);
        s_final    = (r_line == LineW'(MAX_LINES - 1)) || (s_next_dx > {1'b0, r_w[COORD_W-1:0]});
        s_last_pt  = r_bad || (r_pt && s_final);
        s_sel_ceil = ~(r_line[0] ^ r_pt);
        s_a        = s_sel_ceil ? r_cly : r_fly;
        s_b        = s_sel_ceil ? r_cry : r_fry;
    end

    bsp_interp u_interp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.start),
        .i_a     (s_a),
        .i_b     (s_b),
        .i_dx    (r_dx),
        .i_w     (r_w[COORD_W-1:0]),
        .o_done  (s_done),
        .o_y     (s_y)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spacing <= SPACING_RESET;
        end else if (i_cfg_we) begin
            r_spacing <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_clx <= i_cell[0*COORD_W +: COORD_W];
            r_cly <= i_cell[1*COORD_W +: COORD_W];
            r_cry <= i_cell[3*COORD_W +: COORD_W];
            r_fly <= i_cell[4*COORD_W +: COORD_W];
            r_fry <= i_cell[5*COORD_W +: COORD_W];
            r_w   <= {i_cell[3*COORD_W-1], i_cell[2*COORD_W +: COORD_W]}
                   - {i_cell[COORD_W-1], i_cell[0 +: COORD_W]};
        end
        if (i_cmd.init) begin
            r_bad  <= s_bad;
            r_clip <= !s_bad && s_clip;
            r_dx   <= '0;
            r_line <= '0;
            r_pt   <= 1'b0;
        end else if (i_cmd.advance) begin
            if (!r_pt) begin
                r_pt <= 1'b1;
            end else begin
                r_pt   <= 1'b0;
                r_line <= r_line + 1'b1;
                r_dx   <= s_next_dx[COORD_W-1:0];
            end
        end
        if (i_cmd.emit) begin
            r_out_x    <= r_bad ? '0 : r_clx + r_dx;
            r_out_y    <= r_bad ? '0 : s_y;
            r_out_last <= s_last_pt;
            r_out_bad  <= r_bad;
            r_out_clip <= r_clip;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_comb begin
        o_sts.bad      = s_bad;
        o_sts.done     = s_done;
        o_sts.out_free = !r_out_valid || i_out_ready;
        o_sts.last_pt  = s_last_pt;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = {r_out_y, r_out_x};
    assign o_out_last  = r_out_last;
    assign o_out_user  = {r_out_clip, r_out_bad};

endmodule

// ===== sv/bsp_ctrl.sv =====
`timescale 1ns / 1ps
// Controller: sequences loading, checking, one interpolation per point of a valid cell and output.
// Depends on bsp_pkg.
module bsp_ctrl
    import bsp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_RUN,
        S_WAIT,
        S_EMIT
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                o_cmd.init = 1'b1;
                n_state    = i_sts.bad ? S_EMIT : S_RUN;
            end
            S_RUN: begin
                o_cmd.start = 1'b1;
                n_state     = S_WAIT;
            end
            S_WAIT: begin
                if (i_sts.done) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_sts.last_pt) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.advance = 1'b1;
                        n_state       = S_RUN;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

// ===== sv/boustrophedon_sweep_points.sv =====
`timescale 1ns / 1ps
// Top level of the sweep point generator: controller, datapath and the stream ports.
// Depends on bsp_pkg, bsp_ctrl, bsp_dpath.
//
//  channel   direction  width  content
//  s_axis    in         192    one trapezoid cell
//  m_axis    out        64+1+2 one path point, last flag, bad/clipped flags
//  cfg       in         31     sweep spacing, unsigned Q15.16
//
// A cell gives 2 points per sweep line, up to 2*MAX_LINES points, or one point if rejected.
// Each point is computed in turn by the interpolator, whose divide runs in 33 steps.
// Reset is synchronous and active low; the spacing returns to 1.0.
// A stalled output holds the pipeline; a new cell is taken while the last point waits.
module boustrophedon_sweep_points
    import bsp_pkg::*;
#(
    parameter int MAX_LINES = MAX_LINES_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [SPACING_W-1:0]   i_cfg_wdata,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // ceil_left_x, ceil_left_y, ceil_right_x, ceil_right_y, floor_left_y, floor_right_y
    input  logic [6*COORD_W-1:0]   s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // point_x, point_y
    output logic [2*COORD_W-1:0]   m_axis_tdata,
    output logic                   m_axis_tlast,
    // bad_cell, clipped
    output logic [1:0]             m_axis_tuser
);

    t_cmd s_cmd;
    t_sts s_sts;

    bsp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (s_sts),
        .o_cmd      (s_cmd)
    );

    bsp_dpath #(
        .MAX_LINES (MAX_LINES)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cell      (s_axis_tdata),
        .i_cmd       (s_cmd),
        .o_sts       (s_sts),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata),
        .o_out_last  (m_axis_tlast),
        .o_out_user  (m_axis_tuser)
    );

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken while a cell is in progress");

    a_bad_is_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tlast && (m_axis_tdata == '0))
        else $error("rejected cell result is not a single zero point");

    a_bad_not_clipped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> !m_axis_tuser[1])
        else $error("rejected cell flagged as clipped");

    a_emit_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_cmd.emit |-> s_sts.out_free)
        else $error("point written over an unaccepted result");
`endif

endmodule

// ===== test/sweep_point_checker.sv =====
`timescale 1ns / 1ps
// Checker for the sweep point generator: watches the cell, point and spacing channels,
// predicts the path points of every accepted cell and compares them in order.
// Depends on bsp_pkg.
module sweep_point_checker
    import bsp_pkg::*;
#(
    parameter int MAX_LINES = MAX_LINES_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [SPACING_W-1:0]   i_cfg_wdata,
    input  logic                   i_cell_valid,
    input  logic                   i_cell_ready,
    input  logic [6*COORD_W-1:0]   i_cell_data,
    input  logic                   i_point_valid,
    input  logic                   i_point_ready,
    input  logic [2*COORD_W-1:0]   i_point_data,
    input  logic                   i_point_last,
    input  logic [1:0]             i_point_user,
    output int                     o_errors,
    output int                     o_pending
);

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic               last;
        logic               bad;
        logic               clipped;
    } t_point;

    t_point               path_q[$];
    logic [SPACING_W-1:0] spacing = SPACING_RESET;
    int                   mismatches = 0;
    int                   waiting = 0;

    assign o_errors  = mismatches;
    assign o_pending = waiting;

    function automatic logic signed [63:0] lerp_round(input logic signed [63:0] a,
                                                      input logic signed [63:0] b,
                                                      input logic [63:0] dx,
                                                      input logic [63:0] w);
        logic signed [63:0] d;
        logic               neg;
        logic [63:0]        m, q, r, p, mag, rem;
        d   = b - a;
        neg = d < 0;
        m   = neg ? -d : d;
        q   = m / w;
        r   = m % w;
        p   = r * dx;
        mag = q * dx + p / w;
        rem = p % w;
        if ((rem << 1) >= w) begin
            mag = mag + 1;
        end
        return neg ? a - $signed(mag) : a + $signed(mag);
    endfunction

    function automatic void push_point(input logic signed [63:0] x, input logic signed [63:0] y,
                                       input logic last, input logic bad, input logic clip);
        t_point pt;
        pt.x       = x[COORD_W-1:0];
        pt.y       = y[COORD_W-1:0];
        pt.last    = last;
        pt.bad     = bad;
        pt.clipped = clip;
        path_q.push_back(pt);
    endfunction

    function automatic void predict_path(input logic [6*COORD_W-1:0] cell_bits,
                                         input logic [SPACING_W-1:0] step);
        logic signed [63:0] clx, cly, crx, cry, fly, fry, width, x, nx, cy, fy, ny;
        logic [63:0]        w, n, lines;
        logic               clip, down;
        int                 i;
        clx   = $signed(cell_bits[0*COORD_W +: COORD_W]);
        cly   = $signed(cell_bits[1*COORD_W +: COORD_W]);
        crx   = $signed(cell_bits[2*COORD_W +: COORD_W]);
        cry   = $signed(cell_bits[3*COORD_W +: COORD_W]);
        fly   = $signed(cell_bits[4*COORD_W +: COORD_W]);
        fry   = $signed(cell_bits[5*COORD_W +: COORD_W]);
        width = crx - clx;
        if (width <= 0 || step == 0) begin
            push_point(0, 0, 1'b1, 1'b1, 1'b0);
            return;
        end
        w     = width;
        n     = w / step + 1;
        clip  = n > MAX_LINES;
        lines = clip ? MAX_LINES : n;
        down  = 1'b1;
        for (i = 0; i < lines; i++) begin
            x = clx + $signed(64'(i) * 64'(step));
            if (x > crx) begin
                x = crx;
            end
            cy = lerp_round(cly, cry, x - clx, w);
            fy = lerp_round(fly, fry, x - clx, w);
            if (i == 0) begin
                push_point(x, down ? cy : fy, 1'b0, 1'b0, clip);
            end
            push_point(x, down ? fy : cy, i == lines - 1, 1'b0, clip);
            if (i + 1 < lines) begin
                nx = clx + $signed(64'(i + 1) * 64'(step));
                if (nx > crx) begin
                    nx = crx;
                end
                ny = down ? lerp_round(fly, fry, nx - clx, w)
                          : lerp_round(cly, cry, nx - clx, w);
                push_point(nx, ny, 1'b0, 1'b0, clip);
            end
            down = !down;
        end
    endfunction

    function automatic void check_field(input string name, input logic signed [31:0] want,
                                        input logic signed [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_point got, want;
        if (!i_rst_n) begin
            path_q.delete();
            spacing = SPACING_RESET;
        end else begin
            if (i_cfg_we) begin
                spacing = i_cfg_wdata;
            end
            if (i_point_valid && i_point_ready) begin
                got.x       = i_point_data[0 +: COORD_W];
                got.y       = i_point_data[COORD_W +: COORD_W];
                got.last    = i_point_last;
                got.bad     = i_point_user[0];
                got.clipped = i_point_user[1];
                if (path_q.size() == 0) begin
                    $error("unexpected point: x %0d, y %0d", $signed(got.x), $signed(got.y));
                    mismatches++;
                end else begin
                    want = path_q.pop_front();
                    check_field("point_x", want.x, got.x);
                    check_field("point_y", want.y, got.y);
                    check_field("last", want.last, got.last);
                    check_field("bad_cell", want.bad, got.bad);
                    check_field("clipped", want.clipped, got.clipped);
                end
            end
            if (i_cell_valid && i_cell_ready) begin
                predict_path(i_cell_data, spacing);
            end
        end
        waiting = path_q.size();
    end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// Top of the sweep point generator testbench: clock, reset, cell stimulus, spacing writes,
// output stalls and the verdict. Depends on bsp_pkg, boustrophedon_sweep_points and
// sweep_point_checker.
module testbench;
    import bsp_pkg::*;

    localparam int LONG_HOLD      = 3000;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int END_DRAIN      = 200;

    localparam logic signed [31:0] COORD_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] COORD_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] ONE       = 32'sh0001_0000;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_we = 1'b0;
    logic [SPACING_W-1:0]   i_cfg_wdata = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [6*COORD_W-1:0]   s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [2*COORD_W-1:0]   m_axis_tdata;
    logic                   m_axis_tlast;
    logic [1:0]             m_axis_tuser;

    logic                   hold_req = 1'b0;
    int                     stall_cycles = 0;
    int                     errors;
    int                     pending;

    boustrophedon_sweep_points dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    sweep_point_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_cell_valid  (s_axis_tvalid),
        .i_cell_ready  (s_axis_tready),
        .i_cell_data   (s_axis_tdata),
        .i_point_valid (m_axis_tvalid),
        .i_point_ready (m_axis_tready),
        .i_point_data  (m_axis_tdata),
        .i_point_last  (m_axis_tlast),
        .i_point_user  (m_axis_tuser),
        .o_errors      (errors),
        .o_pending     (pending)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin : point_sink
        int  remain;
        int  mode;
        bit  held;
        remain = 0;
        mode   = 0;
        held   = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req && !held) begin
                held = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(negedge i_clk);
            end
            if (remain == 0) begin
                mode   = $urandom_range(0, 3);
                remain = $urandom_range(20, 200);
            end
            remain--;
            case (mode)
                0: m_axis_tready <= 1'b1;
                1: m_axis_tready <= $urandom_range(0, 1);
                2: m_axis_tready <= ($urandom_range(0, 3) == 0);
                default: m_axis_tready <= ((remain / 8) % 2 == 0);
            endcase
        end
    end

    function automatic logic [6*COORD_W-1:0] make_cell(input logic signed [31:0] clx,
                                                       input logic signed [31:0] cly,
                                                       input logic signed [31:0] crx,
                                                       input logic signed [31:0] cry,
                                                       input logic signed [31:0] fly,
                                                       input logic signed [31:0] fry);
        return {fry, fly, cry, crx, cly, clx};
    endfunction

    function automatic logic signed [31:0] random_coord();
        case ($urandom_range(0, 9))
            0: return COORD_MIN;
            1: return COORD_MAX;
            2: return 32'sd0;
            default: return $urandom;
        endcase
    endfunction

    // Most cells get a line count of a few; some are clipped, rejected or fully random.
    function automatic logic [6*COORD_W-1:0] random_cell(input logic [SPACING_W-1:0] spacing);
        logic signed [31:0] a, b, clx, crx;
        logic [63:0]        sp, width, off;
        int                 kind, lines;
        kind = $urandom_range(0, 99);
        a    = $urandom;
        b    = $urandom;
        if (kind < 8) begin
            clx = a;
            crx = b;
        end else if (kind < 14) begin
            clx = (a > b) ? a : b;
            crx = (a > b) ? b : a;
        end else begin
            lines = (kind < 18) ? $urandom_range(32, 40) : $urandom_range(1, 6);
            sp    = (spacing == 0) ? 64'(ONE) : 64'(spacing);
            width = 64'(lines - 1) * sp + 64'($urandom_range(0, 32'(sp - 1)));
            if (width > 64'hFFFF_FFFF) begin
                width = 64'hFFFF_FFFF;
            end
            off = {$urandom, $urandom} % (64'h1_0000_0000 - width);
            clx = off[31:0] ^ 32'h8000_0000;
            crx = clx + width[31:0];
        end
        return make_cell(clx, random_coord(), crx, random_coord(), random_coord(), random_coord());
    endfunction

    task automatic send_cell(input logic [6*COORD_W-1:0] cell_bits);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= cell_bits;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
    endtask

    task automatic write_spacing(input logic [SPACING_W-1:0] value);
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic run_random(input int count, input logic [SPACING_W-1:0] spacing);
        int burst;
        int gap;
        burst = 0;
        for (int k = 0; k < count; k++) begin
            if (k == count / 2) begin
                s_axis_tvalid <= 1'b0;
                wait_drained();
                burst = 0;
            end
            if (burst == 0) begin
                burst = ($urandom_range(0, 4) == 0) ? 20 : $urandom_range(1, 6);
                gap   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                if (gap > 0) begin
                    s_axis_tvalid <= 1'b0;
                    repeat (gap) @(negedge i_clk);
                end
            end
            send_cell(random_cell(spacing));
            burst--;
        end
        s_axis_tvalid <= 1'b0;
    endtask

    initial begin : stimulus
        logic [SPACING_W-1:0] spacing;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_cell(make_cell(0, 0, ONE, 0, 0, 0));
        send_cell(make_cell(100, 5, 100, 6, 7, 8));
        send_cell(make_cell(5, 1, -5, 2, 3, 4));
        send_cell(make_cell(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN));
        send_cell(make_cell(-1000000, 12345, -1000000 + 31 * ONE, -54321, 777, -888));
        send_cell(make_cell(-1000000, 12345, -1000000 + 32 * ONE, -54321, 777, -888));
        send_cell(make_cell(10, 20, 11, 30, 40, 50));
        send_cell(make_cell(10, 20, 10 + ONE - 1, 30, 40, 50));
        send_cell(make_cell(0, 0, 2 * ONE, 1, 0, -1));
        send_cell(make_cell(0, COORD_MIN, 3 * ONE + 7, COORD_MAX, COORD_MAX, COORD_MIN));
        send_cell(make_cell(-1, -1, 2 * ONE - 1, -1, -1, -1));
        send_cell(make_cell(COORD_MAX - 4 * ONE, 3, COORD_MAX, -3, 9, -9));
        send_cell(make_cell(COORD_MIN, 0, COORD_MIN + 5 * ONE, 0, COORD_MAX, COORD_MAX));
        s_axis_tvalid <= 1'b0;

        write_spacing('0);
        send_cell(make_cell(0, 0, 4 * ONE, 1, 2, 3));
        s_axis_tvalid <= 1'b0;
        run_random(8, '0);

        write_spacing(31'd1);
        send_cell(make_cell(-20, 100, 11, -100, 50, -50));
        send_cell(make_cell(-20, 100, 12, -100, 50, -50));
        s_axis_tvalid <= 1'b0;
        run_random(40, 31'd1);

        write_spacing(31'h7FFF_FFFF);
        send_cell(make_cell(COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN, 0, -1));
        s_axis_tvalid <= 1'b0;
        run_random(40, 31'h7FFF_FFFF);

        write_spacing(SPACING_W'(3 * ONE));
        hold_req <= 1'b1;
        run_random(45, SPACING_W'(3 * ONE));

        spacing = SPACING_W'($urandom_range(1, 1 << 20));
        write_spacing(spacing);
        run_random(40, spacing);

        spacing = SPACING_W'($urandom);
        write_spacing(spacing);
        run_random(40, spacing);

        write_spacing(SPACING_W'(ONE));
        run_random(40, SPACING_W'(ONE));

        wait_drained();
        repeat (END_DRAIN) @(posedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
